// ===== rtl/core/tpbse_pkg.sv =====
`default_nettype none
package tpbse_pkg;

  localparam int MAX_W       = 4096;
  localparam int MAX_H       = 4096;
  localparam int PIX_W       = 16;
  localparam int CNT_W       = $clog2(MAX_W);
  localparam int SZ_W        = 13;
  localparam int THR_W       = 17;
  localparam int TAN_W       = 16;
  localparam int ALPHA_W     = 9;
  localparam int ANG_W       = 16;
  localparam int EPOCH_W     = 8;
  localparam int CORD_STEPS  = 16;
  localparam int STEP_W      = 5;
  localparam int ANGLE_LIMIT = 25736;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 80;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_THRESH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAN_X        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAN_Y        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLE  = 3'd6;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_DIVW_GO,
    ST_DIVW,
    ST_DIVH_GO,
    ST_DIVH,
    ST_LUMA,
    ST_UPD,
    ST_ANG,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_go_w;
    logic div_go_h;
    logic sweep_run;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic dirty;
    logic div_done;
    logic sweep_done;
    logic emit;
    logic wrap;
    logic wrap_pend;
    logic cordic_done;
    logic out_free;
  } sts_t;

  // atan(2^-i) in Q2.14, rounded to nearest
  function automatic logic [14:0] atan_q14(input logic [STEP_W-1:0] i);
    logic [14:0] v;
    case (i)
      5'd0:    v = 15'd12868;
      5'd1:    v = 15'd7596;
      5'd2:    v = 15'd4014;
      5'd3:    v = 15'd2037;
      5'd4:    v = 15'd1023;
      5'd5:    v = 15'd512;
      5'd6:    v = 15'd256;
      5'd7:    v = 15'd128;
      5'd8:    v = 15'd64;
      5'd9:    v = 15'd32;
      5'd10:   v = 15'd16;
      5'd11:   v = 15'd8;
      5'd12:   v = 15'd4;
      5'd13:   v = 15'd2;
      5'd14:   v = 15'd1;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tpbse_div.sv =====
`default_nettype none
module tpbse_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [tpbse_pkg::SZ_W-1:0] num,
  input  wire logic [tpbse_pkg::SZ_W-1:0] den,
  output logic                           done,
  output logic [tpbse_pkg::SZ_W-1:0]     quo,
  output logic [tpbse_pkg::SZ_W-1:0]     rem
);
  import tpbse_pkg::*;

  logic [SZ_W-1:0] n_r, q_r, r_r, d_r;
  logic [3:0]      cnt_r;
  logic            busy_r, done_r;
  logic [SZ_W:0]   trial;
  logic            qbit;

  assign trial = {r_r, n_r[SZ_W-1]};
  assign qbit  = (trial >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        n_r    <= num;
        d_r    <= den;
        q_r    <= '0;
        r_r    <= '0;
      end else if (busy_r) begin
        // one quotient bit a cycle, restoring
        r_r   <= qbit ? SZ_W'(trial - {1'b0, d_r}) : SZ_W'(trial);
        q_r   <= {q_r[SZ_W-2:0], qbit};
        n_r   <= {n_r[SZ_W-2:0], 1'b0};
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(SZ_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r;

endmodule
`default_nettype wire

// ===== rtl/core/tpbse_cordic.sv =====
`default_nettype none
module tpbse_cordic (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [tpbse_pkg::CNT_W-1:0] pos,
  input  wire logic [tpbse_pkg::SZ_W-1:0]  size,
  input  wire logic [tpbse_pkg::TAN_W-1:0] tanq,
  output logic                             done,
  output logic signed [tpbse_pkg::ANG_W-1:0] angle
);
  import tpbse_pkg::*;

  localparam int XY_W = 34;
  localparam int Z_W  = 18;

  logic signed [SZ_W+1:0]  d_r;
  logic [SZ_W-1:0]         size_r;
  logic [TAN_W-1:0]        tan_r;
  logic                    mul_r, run_r, done_r;
  logic [STEP_W-1:0]       step_r;
  logic signed [XY_W-1:0]  x_r, y_r, dx, dy, x_nxt, y_nxt;
  logic signed [Z_W-1:0]   z_r, z_nxt, z_at;
  logic signed [ANG_W-1:0] ang_r;
  logic signed [SZ_W+1:0]  d_nxt;

  assign d_nxt = $signed({2'b00, pos, 1'b1}) - $signed({2'b00, size});
  assign dx    = y_r >>> step_r;
  assign dy    = x_r >>> step_r;
  assign z_at  = $signed({3'b000, atan_q14(step_r)});

  always_comb begin
    if (!y_r[XY_W-1]) begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + z_at;
    end else begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - z_at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        d_r    <= d_nxt;
        size_r <= size;
        tan_r  <= tanq;
        mul_r  <= 1'b1;
      end else if (mul_r) begin
        y_r    <= XY_W'($signed(d_r) * $signed({1'b0, tan_r}));
        x_r    <= $signed(XY_W'({size_r, 12'd0}));
        z_r    <= '0;
        step_r <= '0;
        mul_r  <= 1'b0;
        run_r  <= 1'b1;
      end else if (run_r) begin
        x_r    <= x_nxt;
        y_r    <= y_nxt;
        z_r    <= z_nxt;
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(CORD_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
          if (z_nxt > Z_W'(ANGLE_LIMIT))
            ang_r <= ANG_W'(ANGLE_LIMIT);
          else if (z_nxt < -Z_W'(ANGLE_LIMIT))
            ang_r <= -ANG_W'(ANGLE_LIMIT);
          else
            ang_r <= ANG_W'(z_nxt);
        end
      end
    end
  end

  assign done  = done_r;
  assign angle = ang_r;

endmodule
`default_nettype wire

// ===== rtl/core/tpbse_ctrl.sv =====
`default_nettype none
module tpbse_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic            cfg_valid,
  input  wire tpbse_pkg::sts_t sts,
  output tpbse_pkg::cmd_t      cmd
);
  import tpbse_pkg::*;

  state_t state_r, state_nxt;
  logic   ready;

  assign ready = (state_r == ST_IDLE) && !sts.dirty && !cfg_valid;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:     if (sts.sweep_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (sts.dirty) state_nxt = ST_DIVW_GO;
        else if (ready && in_tvalid) state_nxt = ST_LUMA;
      end
      ST_DIVW_GO: state_nxt = ST_DIVW;
      ST_DIVW:    if (sts.div_done) state_nxt = ST_DIVH_GO;
      ST_DIVH_GO: state_nxt = ST_DIVH;
      ST_DIVH:    if (sts.div_done) state_nxt = ST_IDLE;
      ST_LUMA:    state_nxt = ST_UPD;
      ST_UPD: begin
        if (sts.emit) state_nxt = ST_ANG;
        else if (sts.wrap) state_nxt = ST_CLR;
        else state_nxt = ST_IDLE;
      end
      ST_ANG:     if (sts.cordic_done) state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (sts.out_free) state_nxt = sts.wrap_pend ? ST_CLR : ST_IDLE;
      end
      default:    state_nxt = ST_CLR;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_tready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = ready;
        cmd.accept = ready && in_tvalid;
      end
      ST_CLR:     cmd.sweep_run = 1'b1;
      ST_DIVW_GO: cmd.div_go_w  = 1'b1;
      ST_DIVH_GO: cmd.div_go_h  = 1'b1;
      ST_UPD:     cmd.update    = 1'b1;
      ST_LOAD:    cmd.out_load  = sts.out_free;
      default:    cmd           = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLR;
    else        state_r <= state_nxt;
  end

  a_no_accept_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !sts.dirty && !cfg_valid)
    else $error("pixel taken with stale tile geometry");
  a_upd_after_luma: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> ##1 cmd.update)
    else $error("update did not follow accept");
  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

endmodule
`default_nettype wire

// ===== rtl/core/tpbse_dp.sv =====
`default_nettype none
module tpbse_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tpbse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tpbse_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [tpbse_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [tpbse_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  wire tpbse_pkg::cmd_t                   cmd,
  output tpbse_pkg::sts_t                        sts
);
  import tpbse_pkg::*;

  localparam int MEM_W = EPOCH_W + 4 * PIX_W + 2 * CNT_W;

  // configuration
  logic [SZ_W-1:0]         width_r, height_r, tsize_r;
  logic signed [THR_W-1:0] thr_r;
  logic [TAN_W-1:0]        tanx_r, tany_r;
  logic                    mask_r, dirty_r;
  logic [SZ_W-1:0]         w_cl, h_cl, ts_cl;

  // tile geometry from the divider
  logic [SZ_W-1:0] ntx_r, colspan_r, rowspan_r;
  logic            div_sel_w_r, div_done;
  logic [SZ_W-1:0] div_quo, div_rem;

  // raster position
  logic [CNT_W-1:0] col_r, row_r, tc_r, cwt_r, rwt_r;
  logic [CNT_W-1:0] col_nxt, row_nxt, tc_nxt, cwt_nxt, rwt_nxt;
  logic             col_end, row_end, clear_rows;

  // pixel pipeline
  logic [ALPHA_W-1:0]    alpha;
  logic [PIX_W+ALPHA_W-1:0] pr, pg, pb;
  logic [PIX_W-1:0]      sr_r, sg_r, sb_r, luma_r;
  logic                  inb_r, aok_r;
  logic [31:0]           lsum;

  // tile store
  logic [MEM_W-1:0]   mem [MAX_W];
  logic [MEM_W-1:0]   rd_q_r, wdata;
  logic [CNT_W-1:0]   waddr, sw_cnt_r;
  logic               we;
  logic [EPOCH_W-1:0] epoch_r, rd_tag;
  logic [PIX_W-1:0]   rd_luma, rd_r, rd_g, rd_b;
  logic [CNT_W-1:0]   rd_px, rd_py;
  logic               found, better, upd, last, wrap_pend_r;
  logic [PIX_W-1:0]   b_luma, b_r, b_g, b_b;
  logic [CNT_W-1:0]   b_px, b_py;

  // result
  logic [PIX_W-1:0]        or_r, og_r, ob_r;
  logic                    cdone_h, cdone_v, ovalid_r;
  logic signed [ANG_W-1:0] ang_h, ang_v;
  logic [OUT_DATA_W-1:0]   odata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SZ_W'(1920);
      height_r <= SZ_W'(1080);
      tsize_r  <= SZ_W'(4);
      thr_r    <= '0;
      tanx_r   <= TAN_W'(4096);
      tany_r   <= TAN_W'(4096);
      mask_r   <= 1'b0;
      dirty_r  <= 1'b1;
    end else begin
      if (cmd.div_go_w) dirty_r <= 1'b0;
      if (cfg_valid) begin
        dirty_r <= 1'b1;
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_r  <= cfg_data[SZ_W-1:0];
          REG_IMAGE_HEIGHT: height_r <= cfg_data[SZ_W-1:0];
          REG_TILE_SIZE:    tsize_r  <= cfg_data[SZ_W-1:0];
          REG_LUMA_THRESH:  thr_r    <= $signed(cfg_data[THR_W-1:0]);
          REG_TAN_X:        tanx_r   <= cfg_data[TAN_W-1:0];
          REG_TAN_Y:        tany_r   <= cfg_data[TAN_W-1:0];
          REG_MASK_ENABLE:  mask_r   <= cfg_data[0];
          default:          ;
        endcase
      end
    end
  end

  assign cfg_ready = 1'b1;
  assign w_cl  = (width_r == '0)  ? SZ_W'(1) : (width_r  > SZ_W'(MAX_W) ? SZ_W'(MAX_W) : width_r);
  assign h_cl  = (height_r == '0) ? SZ_W'(1) : (height_r > SZ_W'(MAX_H) ? SZ_W'(MAX_H) : height_r);
  assign ts_cl = (tsize_r == '0)  ? SZ_W'(1) : (tsize_r  > SZ_W'(MAX_W) ? SZ_W'(MAX_W) : tsize_r);

  tpbse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go_w || cmd.div_go_h),
    .num   (cmd.div_go_w ? w_cl : h_cl),
    .den   (ts_cl),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // whole tiles span width or height minus remainder
  always_ff @(posedge clk) begin
    if (cmd.div_go_w) div_sel_w_r <= 1'b1;
    if (cmd.div_go_h) div_sel_w_r <= 1'b0;
    if (div_done) begin
      if (div_sel_w_r) begin
        ntx_r     <= div_quo;
        colspan_r <= w_cl - div_rem;
      end else begin
        rowspan_r <= h_cl - div_rem;
      end
    end
  end

  assign alpha = !mask_r ? ALPHA_W'(256) :
                 (in_tdata[56:48] > ALPHA_W'(256) ? ALPHA_W'(256) : in_tdata[56:48]);
  assign pr = (PIX_W+ALPHA_W)'(in_tdata[15:0])  * (PIX_W+ALPHA_W)'(alpha);
  assign pg = (PIX_W+ALPHA_W)'(in_tdata[31:16]) * (PIX_W+ALPHA_W)'(alpha);
  assign pb = (PIX_W+ALPHA_W)'(in_tdata[47:32]) * (PIX_W+ALPHA_W)'(alpha);
  assign lsum = 32'(sr_r) * 32'd13933 + 32'(sg_r) * 32'd46871 + 32'(sb_r) * 32'd4732;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sr_r   <= pr[PIX_W+7:8];
      sg_r   <= pg[PIX_W+7:8];
      sb_r   <= pb[PIX_W+7:8];
      aok_r  <= (alpha != '0);
      inb_r  <= ({1'b0, col_r} < colspan_r) && ({1'b0, row_r} < rowspan_r) &&
                ({1'b0, tc_r} < ntx_r);
      rd_q_r <= mem[tc_r];
    end
    luma_r <= lsum[31:16];
    if (we) mem[waddr] <= wdata;
  end

  assign {rd_tag, rd_luma, rd_r, rd_g, rd_b, rd_px, rd_py} = rd_q_r;
  assign found  = (rd_tag == epoch_r);
  assign better = !found || (luma_r > rd_luma);
  assign upd    = inb_r && aok_r && better;
  assign b_luma = upd ? luma_r : rd_luma;
  assign b_r    = upd ? sr_r : rd_r;
  assign b_g    = upd ? sg_r : rd_g;
  assign b_b    = upd ? sb_r : rd_b;
  assign b_px   = upd ? col_r : rd_px;
  assign b_py   = upd ? row_r : rd_py;
  assign last   = inb_r && (found || upd) &&
                  ({1'b0, cwt_r} + SZ_W'(1) >= ts_cl) &&
                  ({1'b0, rwt_r} + SZ_W'(1) >= ts_cl) &&
                  ($signed({2'b00, b_luma}) > $signed({thr_r[THR_W-1], thr_r}));

  // tag 0 marks an entry as empty; live epochs run 1 up to all ones
  assign we    = (cmd.update && upd) || cmd.sweep_run;
  assign waddr = cmd.sweep_run ? sw_cnt_r : tc_r;
  assign wdata = cmd.sweep_run ? '0 : {epoch_r, luma_r, sr_r, sg_r, sb_r, col_r, row_r};

  always_comb begin
    col_end    = ({1'b0, col_r} + SZ_W'(1) >= w_cl);
    row_end    = ({1'b0, row_r} + SZ_W'(1) >= h_cl);
    col_nxt    = col_r + CNT_W'(1);
    row_nxt    = row_r;
    tc_nxt     = tc_r;
    cwt_nxt    = cwt_r + CNT_W'(1);
    rwt_nxt    = rwt_r;
    clear_rows = 1'b0;
    if (col_end) begin
      col_nxt = '0;
      tc_nxt  = '0;
      cwt_nxt = '0;
      if (row_end) begin
        row_nxt = '0;
        rwt_nxt = '0;
      end else begin
        row_nxt = row_r + CNT_W'(1);
        rwt_nxt = ({1'b0, rwt_r} + SZ_W'(1) >= ts_cl) ? '0 : rwt_r + CNT_W'(1);
      end
      clear_rows = (rwt_nxt == '0);
    end else if ({1'b0, cwt_r} + SZ_W'(1) >= ts_cl) begin
      cwt_nxt = '0;
      tc_nxt  = tc_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      tc_r        <= '0;
      cwt_r       <= '0;
      rwt_r       <= '0;
      epoch_r     <= EPOCH_W'(1);
      wrap_pend_r <= 1'b0;
      sw_cnt_r    <= '0;
    end else begin
      if (cmd.update) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        tc_r  <= tc_nxt;
        cwt_r <= cwt_nxt;
        rwt_r <= rwt_nxt;
        if (clear_rows) begin
          if (&epoch_r) wrap_pend_r <= 1'b1;
          else          epoch_r     <= epoch_r + EPOCH_W'(1);
        end
      end
      if (cmd.sweep_run) begin
        sw_cnt_r <= sw_cnt_r + CNT_W'(1);
        if (&sw_cnt_r) begin
          epoch_r     <= EPOCH_W'(1);
          wrap_pend_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && last) begin
      or_r <= b_r;
      og_r <= b_g;
      ob_r <= b_b;
    end
  end

  tpbse_cordic u_cordic_h (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.update && last),
    .pos   (b_px),
    .size  (w_cl),
    .tanq  (tanx_r),
    .done  (cdone_h),
    .angle (ang_h)
  );

  tpbse_cordic u_cordic_v (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.update && last),
    .pos   (b_py),
    .size  (h_cl),
    .tanq  (tany_r),
    .done  (cdone_v),
    .angle (ang_v)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.out_load)      ovalid_r <= 1'b1;
      else if (out_tready)   ovalid_r <= 1'b0;
    end
    if (cmd.out_load) odata_r <= {ob_r, og_r, or_r, ang_v, ang_h};
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  always_comb begin
    sts             = '0;
    sts.dirty       = dirty_r;
    sts.div_done    = div_done;
    sts.sweep_done  = cmd.sweep_run && (&sw_cnt_r);
    sts.emit        = last;
    sts.wrap        = clear_rows && (&epoch_r);
    sts.wrap_pend   = wrap_pend_r;
    sts.cordic_done = cdone_h;
    sts.out_free    = !ovalid_r || out_tready;
  end

  a_lanes_together: assert property (@(posedge clk) disable iff (!rst_n)
    cdone_h == cdone_v)
    else $error("angle lanes out of step");
  a_epoch_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sweep_run && (&sw_cnt_r)) |=> (epoch_r == EPOCH_W'(1)) && !wrap_pend_r)
    else $error("epoch not restarted after sweep");
  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != '0)
    else $error("live epoch collides with empty tag");

endmodule
`default_nettype wire

// ===== rtl/core/tile_peak_bright_source_extractor.sv =====
// Tile peak bright-source extractor.
// in_*  : pixel words, in raster order. in_tdata = red[15:0], green[31:16],
//         blue[47:32], alpha[56:48] (Q1.8), zero fill above.
// out_* : one word per emitting tile. out_tdata = angle_horizontal[15:0],
//         angle_vertical[31:16], red[47:32], green[63:48], blue[79:64].
// cfg_* : register writes, cfg_index selects the register, always ready.
// Each pixel passes accept (memory read of the tile entry), luma and
// update of the tile entry. A pixel that closes a tile with a peak above
// threshold then passes a multiply step, the CORDIC iterations, a done step
// and a load step that waits for room in the output register and sets
// out_tvalid; the next pixel is taken only after the load.
// A configuration write makes the block recompute tile counts with a
// 13-step divider run twice, in_tready low until the second run is done.
// After reset a pass over all 4096 entries empties the tile store, then the divide runs.
// The same pass repeats once every 255 tile rows (epoch tag wrap).
// The output register holds a result while out_tready is low; new pixels are
// still taken until a second result has to wait for room.
`default_nettype none
module tile_peak_bright_source_extractor (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [tpbse_pkg::IN_DATA_W-1:0]     in_tdata,   // red, green, blue, alpha
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [tpbse_pkg::OUT_DATA_W-1:0]         out_tdata,  // ang_h, ang_v, red, green, blue
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tpbse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tpbse_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tpbse_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tpbse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_valid (cfg_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  tpbse_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire
